// ----- design/dictionary_encoder_core_assert.svh -----
// assertion macros for the dictionary encoder rtl
// used through `include by denc_ctrl, the module that checks its own logic
`ifndef DICTIONARY_ENCODER_CORE_ASSERT_SVH
`define DICTIONARY_ENCODER_CORE_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define DENC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define DENC_NEVER(label, expr, msg) \
	`DENC_ASSERT(label, !(expr), msg)

`endif

// ----- design/denc_pkg.sv -----
// shared types and constants of the dictionary encoder
// no dependencies
package denc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DICT_DEPTH_DEF  = 256;
	localparam int VALUE_PORT_W    = 32;
	localparam int INDEX_PORT_W    = 8;
	localparam int STATUS_W        = 2;

	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_DECODE = 1'b1
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_UNFILLED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DEC_READ,
		ST_DEC_DATA,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_cmd_t;

endpackage

// ----- design/denc_store.sv -----
// dictionary entry memory: one write port, one read port, registered read data
// depends on denc_pkg
module denc_store import denc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int DICT_DEPTH  = DICT_DEPTH_DEF,
	localparam int IW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1
) (
	input  logic                   clk,
	input  mem_cmd_t               mem_cmd,
	input  logic [IW-1:0]          waddr,
	input  logic [VALUE_WIDTH-1:0] wdata,
	input  logic [IW-1:0]          raddr,
	output logic [VALUE_WIDTH-1:0] rdata
);

	logic [VALUE_WIDTH-1:0] mem [DICT_DEPTH];
	logic [VALUE_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/denc_ctrl.sv -----
// sequencer of the dictionary encoder: in-order search, append and decode
// depends on denc_pkg and dictionary_encoder_core_assert.svh
`include "dictionary_encoder_core_assert.svh"

module denc_ctrl import denc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int DICT_DEPTH  = DICT_DEPTH_DEF,
	localparam int IW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1,
	localparam int CW = $clog2(DICT_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    action,
	input  logic [VALUE_PORT_W-1:0] in_value,
	input  logic [INDEX_PORT_W-1:0] in_index,
	input  logic                    slot_free,
	output logic                    res_load,
	output logic [INDEX_PORT_W-1:0] res_index,
	output logic [VALUE_PORT_W-1:0] res_value,
	output logic                    res_is_new,
	output status_t                 res_status,
	output mem_cmd_t                mem_cmd,
	output logic [IW-1:0]           mem_raddr,
	output logic [IW-1:0]           mem_waddr,
	output logic [VALUE_WIDTH-1:0]  mem_wdata,
	input  logic [VALUE_WIDTH-1:0]  mem_rdata
);

	ctrl_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	action_t                 act_q;
	logic [VALUE_WIDTH-1:0]  value_q;
	logic [INDEX_PORT_W-1:0] index_q;
	logic [INDEX_PORT_W-1:0] res_index_q;
	logic [VALUE_PORT_W-1:0] res_value_q;
	logic                    res_new_q;
	status_t                 res_status_q;
	logic                    append_q;

	logic req_take;
	logic hit;
	logic issue;
	logic miss;
	logic dec_ok;
	logic full;
	logic res_set;
	logic [INDEX_PORT_W-1:0] res_index_d;
	logic [VALUE_PORT_W-1:0] res_value_d;
	logic                    res_new_d;
	status_t                 res_status_d;
	logic                    append_d;

	assign req_take = req_valid && !req_stall;
	assign hit      = vld_s1 && (mem_rdata == value_q);
	assign issue    = (state_q == ST_SEARCH) && (rd_ptr_q < count_q) && !hit;
	// all filled entries compared and nothing left in flight
	assign miss     = !vld_s1 && !(rd_ptr_q < count_q);
	assign dec_ok   = 32'(index_q) < 32'(count_q);
	assign full     = count_q == CW'(DICT_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (action == ACT_DECODE) ? ST_DEC_READ : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || miss) begin
					state_d = ST_RESULT;
				end
			end
			ST_DEC_READ: begin
				state_d = ST_DEC_DATA;
			end
			ST_DEC_DATA: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall     = 1'b1;
		mem_cmd.rd_en = 1'b0;
		mem_cmd.wr_en = 1'b0;
		mem_raddr     = rd_ptr_q[IW-1:0];
		res_load      = 1'b0;
		res_set       = 1'b0;
		res_index_d   = '0;
		res_value_d   = '0;
		res_new_d     = 1'b0;
		res_status_d  = STATUS_OK;
		append_d      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_SEARCH: begin
				mem_cmd.rd_en = issue;
				if (hit) begin
					res_set     = 1'b1;
					res_index_d = 8'(idx_s1);
				end else if (miss) begin
					res_set = 1'b1;
					if (full) begin
						res_status_d = STATUS_FULL;
					end else begin
						res_index_d = 8'(count_q);
						res_new_d   = 1'b1;
						append_d    = 1'b1;
					end
				end
			end
			ST_DEC_READ: begin
				mem_cmd.rd_en = dec_ok;
				mem_raddr     = IW'(index_q);
			end
			ST_DEC_DATA: begin
				res_set     = 1'b1;
				res_index_d = index_q;
				if (dec_ok) begin
					res_value_d = 32'(mem_rdata);
				end else begin
					res_status_d = STATUS_UNFILLED;
				end
			end
			ST_RESULT: begin
				res_load      = slot_free;
				mem_cmd.wr_en = slot_free && append_q;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (req_take) begin
				rd_ptr_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (mem_cmd.wr_en) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[IW-1:0];
		if (req_take) begin
			act_q   <= action_t'(action);
			value_q <= VALUE_WIDTH'(in_value);
			index_q <= in_index;
		end
		if (res_set) begin
			res_index_q  <= res_index_d;
			res_value_q  <= (act_q == ACT_DECODE) ? res_value_d : '0;
			res_new_q    <= res_new_d;
			res_status_q <= res_status_d;
			append_q     <= append_d;
		end
	end

	assign res_index  = res_index_q;
	assign res_value  = res_value_q;
	assign res_is_new = res_new_q;
	assign res_status = res_status_q;
	assign mem_waddr  = count_q[IW-1:0];
	assign mem_wdata  = value_q;

	`DENC_ASSERT(a_count_bound, count_q <= CW'(DICT_DEPTH), "entry count beyond depth")
	`DENC_NEVER(a_rd_wr_overlap, mem_cmd.rd_en && mem_cmd.wr_en, "read and write together")
	`DENC_ASSERT(a_count_on_write, !$stable(count_q) |-> $past(mem_cmd.wr_en), "count moved without write")
	`DENC_ASSERT(a_write_when_done, mem_cmd.wr_en |-> (state_q == ST_RESULT) && res_load, "stray write")

endmodule

// ----- design/dictionary_encoder_core.sv -----
// top level of the dictionary encoder: sequencer, entry memory, result register
// depends on denc_pkg, denc_store and denc_ctrl
//
// usage:
//   request channel (req_valid, req_stall) carries action, in_value, in_index;
//   an item is taken at a clock edge with req_valid high and req_stall low.
//   response channel (rsp_valid, rsp_stall) carries out_index, out_value,
//   is_new and status; one response per request, in request order.
//   an encode compares the filled entries one per cycle out of the entry
//   memory, from index 0 up to the first match; when none matches the value
//   is appended, or refused if the store is full; a decode reads the entry at
//   in_index when that entry is filled, else it reports it as unfilled.
//   one item is in the sequencer at a time; the memory read port sets the
//   search rate. the response register lets the next item be accepted while
//   a response still waits on a stalled receiver; a finished item then waits
//   in the sequencer until the register frees up.
//   reset clears the entry count and the handshake state; memory contents are
//   left as they are and only entries written since reset are ever read.
module dictionary_encoder_core import denc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int DICT_DEPTH  = DICT_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic                    action,
	input  logic [VALUE_PORT_W-1:0] in_value,
	input  logic [INDEX_PORT_W-1:0] in_index,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [INDEX_PORT_W-1:0] out_index,
	output logic [VALUE_PORT_W-1:0] out_value,
	output logic                    is_new,
	output logic [STATUS_W-1:0]     status
);

	localparam int IW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;

	mem_cmd_t                mem_cmd;
	logic [IW-1:0]           mem_raddr;
	logic [IW-1:0]           mem_waddr;
	logic [VALUE_WIDTH-1:0]  mem_wdata;
	logic [VALUE_WIDTH-1:0]  mem_rdata;
	logic                    slot_free;
	logic                    res_load;
	logic [INDEX_PORT_W-1:0] res_index;
	logic [VALUE_PORT_W-1:0] res_value;
	logic                    res_is_new;
	status_t                 res_status;

	logic                    rsp_valid_q;
	logic [INDEX_PORT_W-1:0] out_index_q;
	logic [VALUE_PORT_W-1:0] out_value_q;
	logic                    is_new_q;
	logic [STATUS_W-1:0]     status_q;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	denc_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DICT_DEPTH (DICT_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.in_value  (in_value),
		.in_index  (in_index),
		.slot_free (slot_free),
		.res_load  (res_load),
		.res_index (res_index),
		.res_value (res_value),
		.res_is_new(res_is_new),
		.res_status(res_status),
		.mem_cmd   (mem_cmd),
		.mem_raddr (mem_raddr),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	denc_store #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DICT_DEPTH (DICT_DEPTH)
	) u_store (
		.clk    (clk),
		.mem_cmd(mem_cmd),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_index_q <= res_index;
			out_value_q <= res_value;
			is_new_q    <= res_is_new;
			status_q    <= res_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign is_new    = is_new_q;
	assign status    = status_q;

endmodule

// ----- tb/dictionary_encoder_checker.sv -----
// checker for the dictionary encoder: watches both channels, predicts each response
// from its own copy of the dictionary and compares field by field; uses denc_pkg
module dictionary_encoder_checker import denc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic                    action,
	input  logic [VALUE_PORT_W-1:0] in_value,
	input  logic [INDEX_PORT_W-1:0] in_index,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic [INDEX_PORT_W-1:0] out_index,
	input  logic [VALUE_PORT_W-1:0] out_value,
	input  logic                    is_new,
	input  logic [STATUS_W-1:0]     status,
	output int                      fail_count,
	output int                      replies_pending,
	output int                      n_appended,
	output int                      n_matched,
	output int                      n_full,
	output int                      n_decoded,
	output int                      n_unfilled
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DICT_DEPTH_DEF;
	localparam logic [VALUE_PORT_W-1:0] VALUE_MASK = (VALUE_WIDTH_DEF >= VALUE_PORT_W) ?
		{VALUE_PORT_W{1'b1}} : ((VALUE_PORT_W'(1) << VALUE_WIDTH_DEF) - 1);

	typedef struct packed {
		logic [INDEX_PORT_W-1:0] index;
		logic [VALUE_PORT_W-1:0] value;
		logic                    fresh;
		status_t                 st;
	} dict_reply_t;

	logic [VALUE_PORT_W-1:0] dict_vals [DEPTH];
	int unsigned             filled;
	dict_reply_t             replies_q [$];
	int                      errs, appended, matched, full_rejects, dec_hits, dec_misses;

	// encode: walks the filled entries in order, appends on a miss while there is room; decode: reads a filled entry
	function automatic dict_reply_t lookup_reply(action_t act, logic [VALUE_PORT_W-1:0] val,
			logic [INDEX_PORT_W-1:0] idx);
		dict_reply_t             r;
		logic [VALUE_PORT_W-1:0] v;
		bit                      found;
		r = '0;
		if (act == ACT_ENCODE) begin
			v = val & VALUE_MASK;
			found = 1'b0;
			for (int i = 0; i < filled && !found; i++) begin
				if (dict_vals[i] == v) begin
					found = 1'b1;
					r.index = INDEX_PORT_W'(i);
					matched++;
				end
			end
			if (!found) begin
				if (filled >= DEPTH) begin
					r.st = STATUS_FULL;
					full_rejects++;
				end else begin
					dict_vals[filled] = v;
					r.index = INDEX_PORT_W'(filled);
					r.fresh = 1'b1;
					filled++;
					appended++;
				end
			end
		end else begin
			r.index = idx;
			if (idx < filled && idx < DEPTH) begin
				r.value = dict_vals[idx] & VALUE_MASK;
				dec_hits++;
			end else begin
				r.st = STATUS_UNFILLED;
				dec_misses++;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dict_reply_t want;
		if (!arst_n) begin
			filled = 0;
			replies_q.delete();
			replies_pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (replies_q.size() == 0) begin
					$error("response with no request waiting: index %0h value %0h", out_index,
						out_value);
					errs++;
				end else begin
					want = replies_q.pop_front();
					if (out_index !== want.index) begin
						$error("out_index: expected %0h, got %0h", want.index, out_index);
						errs++;
					end
					if (out_value !== want.value) begin
						$error("out_value: expected %0h, got %0h", want.value, out_value);
						errs++;
					end
					if (is_new !== want.fresh) begin
						$error("is_new: expected %0b, got %0b", want.fresh, is_new);
						errs++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errs++;
					end
				end
			end
			if (req_valid && !req_stall)
				replies_q.push_back(lookup_reply(action_t'(action), in_value, in_index));
			fail_count      <= errs;
			replies_pending <= replies_q.size();
			n_appended      <= appended;
			n_matched       <= matched;
			n_full          <= full_rejects;
			n_decoded       <= dec_hits;
			n_unfilled      <= dec_misses;
		end
	end

endmodule

// ----- tb/tb_dictionary_encoder_core.sv -----
// testbench top for dictionary_encoder_core: drives requests and response stalls,
// gives the verdict; depends on denc_pkg, the rtl and dictionary_encoder_checker
module tb_dictionary_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;
	import denc_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = DICT_DEPTH_DEF + 16;
	localparam int IDLE_PCT     = 36;
	localparam int N_RANDOM     = 1780;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic                    action    = 1'b0;
	logic [VALUE_PORT_W-1:0] in_value  = '0;
	logic [INDEX_PORT_W-1:0] in_index  = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic [INDEX_PORT_W-1:0] out_index;
	logic [VALUE_PORT_W-1:0] out_value;
	logic                    is_new;
	logic [STATUS_W-1:0]     status;

	int fail_count, replies_pending;
	int n_appended, n_matched, n_full, n_decoded, n_unfilled;
	int cycles;
	int items_sent;
	bit calm;

	// values the dictionary holds, in append order, as the stimulus sees it
	logic [VALUE_PORT_W-1:0] stored_vals [$];
	bit                      is_stored [logic [VALUE_PORT_W-1:0]];

	dictionary_encoder_core i_dut (.*);
	dictionary_encoder_checker i_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_dictionary_encoder_core: done, errors");
			$finish;
		end
	end

	task automatic push_request(action_t act, logic [VALUE_PORT_W-1:0] val,
			logic [INDEX_PORT_W-1:0] idx);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		action    <= act;
		in_value  <= val;
		in_index  <= idx;
		do @(posedge clk); while (req_stall);
		items_sent++;
		if (act == ACT_ENCODE && !is_stored.exists(val) && stored_vals.size() < DICT_DEPTH_DEF)
		begin
			is_stored[val] = 1'b1;
			stored_vals.push_back(val);
		end
	endtask

	initial begin
		logic [VALUE_PORT_W-1:0] v;
		logic [INDEX_PORT_W-1:0] ix;
		int                      pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, extremes, repeats, reads just past the filled range
		push_request(ACT_DECODE, $urandom, 8'd0);
		push_request(ACT_DECODE, $urandom, 8'hff);
		push_request(ACT_ENCODE, 32'h0000_0000, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'hffff_ffff, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'h0000_0000, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'hffff_ffff, INDEX_PORT_W'($urandom));
		push_request(ACT_DECODE, $urandom, 8'd0);
		push_request(ACT_DECODE, $urandom, 8'd1);
		push_request(ACT_DECODE, $urandom, 8'd2);
		push_request(ACT_ENCODE, 32'h8000_0000, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'h0000_0001, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'h7fff_ffff, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'ha5a5_a5a5, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'h5a5a_5a5a, INDEX_PORT_W'($urandom));
		push_request(ACT_DECODE, $urandom, 8'd5);
		push_request(ACT_DECODE, $urandom, 8'd6);
		push_request(ACT_DECODE, $urandom, 8'd7);
		push_request(ACT_DECODE, $urandom, 8'd128);
		push_request(ACT_ENCODE, 32'h0000_0001, INDEX_PORT_W'($urandom));
		push_request(ACT_ENCODE, 32'h5a5a_5a5a, INDEX_PORT_W'($urandom));

		// enough fresh values to fill the store, then mostly hits and full rejects
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 600 && n < 900);
			if ($urandom_range(0, 99) < 60) begin
				pick = $urandom_range(0, 99);
				if (pick < 50 || stored_vals.size() == 0)
					v = $urandom;
				else if (pick < 85)
					v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
				else
					v = $urandom_range(0, 15);
				push_request(ACT_ENCODE, v, INDEX_PORT_W'($urandom));
			end else begin
				if (stored_vals.size() > 0 && $urandom_range(0, 99) < 70)
					ix = INDEX_PORT_W'($urandom_range(0, stored_vals.size() - 1));
				else
					ix = INDEX_PORT_W'($urandom_range(0, 255));
				push_request(ACT_DECODE, $urandom, ix);
			end
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		@(posedge clk);
		while (replies_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d requests, %0d appends, %0d repeat hits, %0d full rejects",
			items_sent, n_appended, n_matched, n_full);
		$display("decodes: %0d of filled entries, %0d of unfilled indexes", n_decoded, n_unfilled);
		if (fail_count == 0 && replies_pending == 0)
			$display("tb_dictionary_encoder_core: done, clean");
		else
			$display("tb_dictionary_encoder_core: done, errors");
		$finish;
	end

endmodule
